// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the pattern search.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== hdl/wbps_pkg.sv =====
// Types and constants of the wildcard byte pattern search.
`timescale 1ns / 1ps
`default_nettype none
package wbps_pkg;

  localparam int BYTE_W    = 8;
  localparam int REG_W     = 64;
  localparam int MASK_W    = 16;
  localparam int LEN_W     = 5;
  localparam int OFFSET_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [MASK_W-1:0] ANY_POS_MASK = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_WILDCARD = 2'd2,
    CFG_LENGTH   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_ONE  = 2'd1,
    STATUS_MANY = 2'd2
  } status_e;

  typedef struct packed {
    logic             accept;
    logic             last;
    logic             hit;
    logic [LEN_W-1:0] len;
  } scan_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/wbps_cell.sv =====
// One window cell: holds a byte, passes it on and compares the incoming byte.
`timescale 1ns / 1ps
`default_nettype none
module wbps_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      shift_i,
  input  wire logic                      clear_i,
  input  wire logic [wbps_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [wbps_pkg::BYTE_W-1:0] pat_i,
  input  wire logic                      care_i,
  output logic      [wbps_pkg::BYTE_W-1:0] byte_o,
  output logic                           hit_o
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !care_i || (byte_i == pat_i);

endmodule
`default_nettype wire

// ===== hdl/wbps_result.sv =====
// Offset counter, match tally and two-entry result buffer.
`timescale 1ns / 1ps
`default_nettype none
module wbps_result #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wbps_pkg::scan_ctl_t         ctl_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output wbps_pkg::status_e                status_o,
  output logic      [wbps_pkg::OFFSET_W-1:0] offset_o,
  output logic                             in_ready_o
);
  import wbps_pkg::*;

  localparam int ExtW = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

  logic [OFFSET_BITS-1:0] seen_q, seen_d, seen_inc;
  logic [OFFSET_BITS-1:0] first_q, first_d;
  status_e                tally_q, tally_d;
  logic                   hit_now;
  logic [ExtW-1:0]        first_ext;
  logic [OFFSET_W-1:0]    res_offset;

  logic                   out_v_q, skid_v_q;
  status_e                out_st_q, skid_st_q;
  logic [OFFSET_W-1:0]    out_off_q, skid_off_q;
  logic                   push, pop;

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 1'b1;
  assign hit_now  = ctl_i.hit && (seen_inc >= OFFSET_BITS'(ctl_i.len));

  always_comb begin
    seen_d  = seen_q;
    first_d = first_q;
    tally_d = tally_q;
    if (ctl_i.accept) begin
      seen_d = seen_inc;
      if (hit_now) begin
        case (tally_q)
          STATUS_NONE: begin
            first_d = seen_inc - OFFSET_BITS'(ctl_i.len);
            tally_d = STATUS_ONE;
          end
          STATUS_ONE:  tally_d = STATUS_MANY;
          STATUS_MANY: tally_d = STATUS_MANY;
          default:     tally_d = STATUS_MANY;
        endcase
      end
    end
  end

  assign first_ext  = ExtW'(first_d);
  always_comb begin
    if (tally_d == STATUS_NONE) begin
      res_offset = '0;
    end else if (first_ext > ExtW'({OFFSET_W{1'b1}})) begin
      res_offset = '1;
    end else begin
      res_offset = first_ext[OFFSET_W-1:0];
    end
  end

  assign push = ctl_i.accept && ctl_i.last;
  assign pop  = out_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      first_q <= '0;
      tally_q <= STATUS_NONE;
    end else if (push) begin
      seen_q  <= '0;
      first_q <= '0;
      tally_q <= STATUS_NONE;
    end else begin
      seen_q  <= seen_d;
      first_q <= first_d;
      tally_q <= tally_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= push;
      end else begin
        out_v_q  <= push;
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_st_q   <= skid_st_q;
        out_off_q  <= skid_off_q;
        skid_st_q  <= tally_d;
        skid_off_q <= res_offset;
      end else begin
        out_st_q  <= tally_d;
        out_off_q <= res_offset;
      end
    end else if (push) begin
      skid_st_q  <= tally_d;
      skid_off_q <= res_offset;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_st_q;
  assign offset_o    = out_off_q;
  assign in_ready_o  = !skid_v_q;

endmodule
`default_nettype wire

// ===== hdl/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// The block takes one byte of the scanned region in every clock cycle while
// input ready is high and compares the pattern against the newest bytes in the
// same cycle, through a row of MAX_PATTERN cells that each hold one window byte
// and check the byte entering them against the pattern byte aligned to the current
// length. When the word flagged last is taken, its result (status and start
// offset of the first match) is registered into a two-entry result buffer, which
// lets bytes keep flowing while a result waits; input ready falls only when both
// entries are full. Configuration writes take effect on the next byte.
module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // data_byte in bits 7:0
  input  wire logic [7:0]                     s_axis_tdata_i,
  // last_byte
  input  wire logic                           s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // status in bits 1:0, first_offset in bits 33:2, zeros above
  output logic      [39:0]                    m_axis_tdata_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [wbps_pkg::REG_W-1:0]     cfg_wdata_i
);
  import wbps_pkg::*;

  logic [REG_W-1:0]  pat_low_q, pat_high_q;
  logic [MASK_W-1:0] wild_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  len_used;
  logic [2*REG_W/BYTE_W-1:0][BYTE_W-1:0] pat_all;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cell_in, cell_out, cell_pat;
  logic [MAX_PATTERN-1:0]             cell_care, cell_hit;
  logic                               accept;
  scan_ctl_t                          ctl;
  status_e                            out_status;
  logic [OFFSET_W-1:0]                out_offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        CFG_WILDCARD: wild_q     <= cfg_wdata_i[MASK_W-1:0] & ANY_POS_MASK;
        CFG_LENGTH:   len_q      <= cfg_wdata_i[LEN_W-1:0];
        default:      len_q      <= len_q;
      endcase
    end
  end

  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    if (len_q == '0) begin
      len_used = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN)) begin
      len_used = LEN_W'(MAX_PATTERN);
    end else begin
      len_used = len_q;
    end
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LEN_W-1:0] pos;
    assign pos = len_used - LEN_W'(j) - LEN_W'(1);
    assign cell_pat[j]  = pat_all[pos[3:0]];
    assign cell_care[j] = (LEN_W'(j) < len_used) && !wild_q[pos[3:0]];
    if (j == 0) begin : g_head
      assign cell_in[j] = s_axis_tdata_i;
    end else begin : g_body
      assign cell_in[j] = cell_out[j-1];
    end

    wbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (accept && s_axis_tlast_i),
      .byte_i  (cell_in[j]),
      .pat_i   (cell_pat[j]),
      .care_i  (cell_care[j]),
      .byte_o  (cell_out[j]),
      .hit_o   (cell_hit[j])
    );
  end

  assign ctl.accept = accept;
  assign ctl.last   = s_axis_tlast_i;
  assign ctl.hit    = &cell_hit;
  assign ctl.len    = len_used;

  wbps_result #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .status_o    (out_status),
    .offset_o    (out_offset),
    .in_ready_o  (s_axis_tready_o)
  );

  assign m_axis_tdata_o = {6'b0, out_offset, out_status};

  `ASSERT_CLK(a_stall_needs_result, !s_axis_tready_o |-> m_axis_tvalid_o,
              "input stalled while no result is pending")
  `ASSERT_NEVER(a_status_code, m_axis_tvalid_o && (m_axis_tdata_o[1:0] == 2'd3),
                "invalid status code on output")
  `ASSERT_CLK(a_none_zero_offset,
              (m_axis_tvalid_o && (m_axis_tdata_o[1:0] == STATUS_NONE)) |->
              (m_axis_tdata_o[33:2] == '0),
              "nonzero offset reported without a match")
  `ASSERT_CLK(a_last_gives_result,
              (accept && s_axis_tlast_i) |=> m_axis_tvalid_o,
              "last word accepted but no result pending")

endmodule
`default_nettype wire
